// ===== sv/sam_pkg.sv =====
`timescale 1ns / 1ps
// sam_pkg: shared types, constants and lookup functions of the sprite attribute memory
// used by sam_controller, sam_datapath and sprite_attribute_memory; no dependencies
package sam_pkg;

   // memory geometry
   localparam int OBJECT_COUNT   = 128;
   localparam int HALFWORD_COUNT = OBJECT_COUNT * 4;
   localparam int HW_ADDR_W      = $clog2(HALFWORD_COUNT);

   // field widths
   localparam int ADDR_W    = 10;
   localparam int DATA_W    = 32;
   localparam int OBJ_IDX_W = 7;
   localparam int DIM_W     = 7;

   // stream payload widths; the tdata widths are padded to whole bytes
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 56;

   // access kind and size codes
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_MEM,
      ST_WRITE_LO,
      ST_WRITE_HI,
      ST_FETCH_ATTR,
      ST_RESPOND
   } sam_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic write_lo;
      logic write_hi;
      logic read_mem;
      logic fetch_attr;
      logic load_rsp;
   } sam_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic is_word;
      logic rsp_free;
   } sam_status_type;

   // sprite width from {shape, size}; invalid shape gives 8
   function automatic logic [DIM_W-1:0] sprite_width(input logic [3:0] code);
      logic [DIM_W-1:0] w;
      case (code)
         4'h0: w = 7'd8;
         4'h1: w = 7'd16;
         4'h2: w = 7'd32;
         4'h3: w = 7'd64;
         4'h4: w = 7'd16;
         4'h5: w = 7'd32;
         4'h6: w = 7'd32;
         4'h7: w = 7'd64;
         4'h8: w = 7'd8;
         4'h9: w = 7'd8;
         4'hA: w = 7'd16;
         4'hB: w = 7'd32;
         default: w = 7'd8;
      endcase
      return w;
   endfunction

   // sprite height from {shape, size}; invalid shape gives 8
   function automatic logic [DIM_W-1:0] sprite_height(input logic [3:0] code);
      logic [DIM_W-1:0] h;
      case (code)
         4'h0: h = 7'd8;
         4'h1: h = 7'd16;
         4'h2: h = 7'd32;
         4'h3: h = 7'd64;
         4'h4: h = 7'd8;
         4'h5: h = 7'd8;
         4'h6: h = 7'd16;
         4'h7: h = 7'd32;
         4'h8: h = 7'd16;
         4'h9: h = 7'd32;
         4'hA: h = 7'd32;
         4'hB: h = 7'd64;
         default: h = 7'd8;
      endcase
      return h;
   endfunction

endpackage

// ===== sv/sam_controller.sv =====
`timescale 1ns / 1ps
// sam_controller: sequencing state machine of the sprite attribute memory
// depends on sam_pkg; drives sam_datapath through sam_cmd_type
module sam_controller
   import sam_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  sam_status_type status,
   output sam_cmd_type    cmd
);

   sam_state_type state_ff;
   sam_state_type state_in;
   logic          req_is_write_now;

   assign req_is_write_now = status.is_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_WRITE_LO;
            end
         end
         ST_READ_MEM:   state_in = ST_RESPOND;
         ST_WRITE_LO: begin
            state_in = status.is_word ? ST_WRITE_HI : ST_FETCH_ATTR;
         end
         ST_WRITE_HI:   state_in = ST_FETCH_ATTR;
         ST_FETCH_ATTR: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
      // in idle the kind of the new transaction comes from the port; reads skip the writes
      if (state_ff == ST_IDLE && req_tvalid && !req_is_write_now) begin
         state_in = ST_READ_MEM;
      end
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = !reset;
            cmd.load_req = req_tvalid && !reset;
         end
         ST_READ_MEM:   cmd.read_mem   = 1'b1;
         ST_WRITE_LO:   cmd.write_lo   = 1'b1;
         ST_WRITE_HI:   cmd.write_hi   = 1'b1;
         ST_FETCH_ATTR: cmd.fetch_attr = 1'b1;
         ST_RESPOND:    cmd.load_rsp   = status.rsp_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_READ_MEM || state_ff == ST_WRITE_LO))
      else $error("accepted transaction did not start a read or a write");

   a_high_half_only_for_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE_HI) |-> ($past(state_ff) == ST_WRITE_LO && status.is_word))
      else $error("high half written outside a word write");

   a_respond_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESPOND && $past(state_ff) != ST_RESPOND) |->
      ($past(state_ff) == ST_READ_MEM || $past(state_ff) == ST_FETCH_ATTR))
      else $error("response built without a memory read");
`endif

endmodule

// ===== sv/sam_datapath.sv =====
`timescale 1ns / 1ps
// sam_datapath: request latch, 512 x 16 attribute memory, size lookup and result register
// depends on sam_pkg; steered by sam_controller
module sam_datapath
   import sam_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  sam_cmd_type          cmd,
   output sam_status_type       status,
   input  logic                 req_type,
   input  logic [1:0]           access_size,
   input  logic [ADDR_W-1:0]    address,
   input  logic [DATA_W-1:0]    write_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    read_data,
   output logic [OBJ_IDX_W-1:0] object_index,
   output logic [DIM_W-1:0]     object_width,
   output logic [DIM_W-1:0]     object_height
);

   // latched request
   logic              req_write_ff;
   logic [1:0]        req_size_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [DATA_W-1:0] req_wdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_write_ff <= req_type;
         req_size_ff  <= access_size;
         req_addr_ff  <= address;
         req_wdata_ff <= write_data;
      end
   end

   logic                 is_word;
   logic                 is_byte;
   logic [HW_ADDR_W-1:0] slot;
   logic [HW_ADDR_W-1:0] slot_lo;
   logic [HW_ADDR_W-1:0] slot_hi;
   logic [HW_ADDR_W-1:0] attr0_slot;
   logic [OBJ_IDX_W-1:0] obj;

   assign is_word    = (req_size_ff == SIZE_WORD);
   assign is_byte    = (req_size_ff == SIZE_BYTE);
   assign slot       = HW_ADDR_W'(req_addr_ff >> 1);
   assign slot_lo    = {slot[HW_ADDR_W-1:1], 1'b0};
   assign slot_hi    = {slot[HW_ADDR_W-1:1], 1'b1};
   assign attr0_slot = {slot[HW_ADDR_W-1:2], 2'b00};
   assign obj        = OBJ_IDX_W'(slot >> 2);

   // memory ports
   logic                 wr_en;
   logic [HW_ADDR_W-1:0] wr_addr;
   logic [15:0]          wr_data;
   logic                 rd_en;
   logic [HW_ADDR_W-1:0] rd_addr_a;
   logic [HW_ADDR_W-1:0] rd_addr_b;

   always_comb begin
      wr_en   = cmd.write_lo || cmd.write_hi;
      wr_addr = slot;
      wr_data = req_wdata_ff[15:0];
      if (cmd.write_hi) begin
         wr_addr = slot_hi;
         wr_data = req_wdata_ff[31:16];
      end else if (is_word) begin
         wr_addr = slot_lo;
      end else if (is_byte) begin
         wr_data = {req_wdata_ff[7:0], req_wdata_ff[7:0]};
      end
   end

   always_comb begin
      rd_en     = cmd.read_mem || cmd.fetch_attr;
      rd_addr_a = is_word ? slot_lo : slot;
      rd_addr_b = slot_hi;
      if (cmd.fetch_attr) begin
         rd_addr_a = attr0_slot;
         rd_addr_b = attr0_slot | HW_ADDR_W'(1);
      end
   end

   logic [15:0] attr_mem_ff [HALFWORD_COUNT];
   logic [15:0] rd_a_ff;
   logic [15:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         attr_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= attr_mem_ff[rd_addr_a];
         rd_b_ff <= attr_mem_ff[rd_addr_b];
      end
   end

   // result assembly
   logic [DATA_W-1:0] rdata_in;
   logic [DIM_W-1:0]  width_in;
   logic [DIM_W-1:0]  height_in;

   always_comb begin
      rdata_in  = '0;
      width_in  = '0;
      height_in = '0;
      if (req_write_ff == REQ_WRITE) begin
         width_in  = sprite_width({rd_a_ff[15:14], rd_b_ff[15:14]});
         height_in = sprite_height({rd_a_ff[15:14], rd_b_ff[15:14]});
      end else if (is_word) begin
         rdata_in = {rd_b_ff, rd_a_ff};
      end else if (is_byte) begin
         rdata_in = {24'd0, (req_addr_ff[0] ? rd_a_ff[15:8] : rd_a_ff[7:0])};
      end else begin
         rdata_in = {16'd0, rd_a_ff};
      end
   end

   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_rdata_ff;
   logic [OBJ_IDX_W-1:0] rsp_obj_ff;
   logic [DIM_W-1:0]     rsp_width_ff;
   logic [DIM_W-1:0]     rsp_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_rdata_ff  <= rdata_in;
         rsp_obj_ff    <= obj;
         rsp_width_ff  <= width_in;
         rsp_height_ff <= height_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign read_data     = rsp_rdata_ff;
   assign object_index  = rsp_obj_ff;
   assign object_width  = rsp_width_ff;
   assign object_height = rsp_height_ff;

   // in idle the kind comes straight from the port, later from the latch
   assign status.is_write = cmd.load_req ? (req_type == REQ_WRITE) : (req_write_ff == REQ_WRITE);
   assign status.is_word  = is_word;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before being taken");

   a_write_result_has_size: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && req_write_ff == REQ_WRITE) |=> (rsp_rdata_ff == '0 && rsp_width_ff != '0))
      else $error("write result carries read data or no sprite size");

   a_one_port_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_lo, cmd.write_hi, cmd.read_mem, cmd.fetch_attr}))
      else $error("more than one memory action in a cycle");
`endif

endmodule

// ===== sv/sprite_attribute_memory.sv =====
`timescale 1ns / 1ps
// sprite_attribute_memory: top level of the 1 KiB sprite attribute memory
// depends on sam_pkg, sam_controller and sam_datapath
//
// Sprite attribute memory of 128 sprites, four 16-bit halfwords each (512 x 16). Every request
// transaction is one bus access, a read or a write of a byte, a halfword or a word, and gives
// exactly one response transaction. A word touches two halfwords, low half first; a byte write
// stores the byte in both bytes of its halfword; a byte read returns the addressed byte, zero
// extended. Responses carry the touched sprite's index; after a write they also carry its pixel
// width and height, looked up from shape (attr0 bits 15:14) and size (attr1 bits 15:14), with
// the invalid shape giving 8x8. Reads report width and height as zero, writes report zero data.
// The memory is not cleared at reset: reading a halfword that was never written, or writing to
// a sprite whose attr0 or attr1 was never written, returns undefined fields. The block handles
// one transaction at a time, paced by the single write port and the registered read of the
// memory: a read passes through accept, memory read and response load; a byte or halfword
// write passes through accept, write, attr0 and attr1 read together, and response load; a word
// write adds a high-half write after the low-half write. A new request is taken while the
// previous response still waits in the output register; a response that finds that register
// still occupied waits until it drains, and the input stalls meanwhile.
module sprite_attribute_memory
   import sam_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // address[9:0], write_data[41:10], zero pad
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // req_type[0], access_size[2:1]
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // read_data[31:0], object_index[38:32],
                                               // object_width[45:39], object_height[52:46],
                                               // zero pad
);

   sam_cmd_type    cmd;
   sam_status_type status;

   // request unpacking
   logic              req_type;
   logic [1:0]        access_size;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   assign req_type    = req_tuser[0];
   assign access_size = req_tuser[2:1];
   assign address     = req_tdata[ADDR_W-1:0];
   assign write_data  = req_tdata[ADDR_W+DATA_W-1:ADDR_W];

   // response fields
   logic [DATA_W-1:0]    read_data;
   logic [OBJ_IDX_W-1:0] object_index;
   logic [DIM_W-1:0]     object_width;
   logic [DIM_W-1:0]     object_height;

   sam_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sam_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_type),
      .access_size   (access_size),
      .address       (address),
      .write_data    (write_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .read_data     (read_data),
      .object_index  (object_index),
      .object_width  (object_width),
      .object_height (object_height)
   );

   // response packing, upper pad bits held at zero
   assign rsp_tdata = {
      (RSP_TDATA_W - DATA_W - OBJ_IDX_W - 2*DIM_W)'(0),
      object_height,
      object_width,
      object_index,
      read_data
   };

endmodule
